// File: hw/rtl/rsc_pkg.sv
// Shared types, codes and constants of the RPN stack calculator.
package rsc_pkg;

  localparam int STACK_DEPTH_DEF = 32;
  localparam int DUMP_MAX        = 32;
  localparam int WORD_W          = 32;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  // Neighbor select of a stack slot: code 3 holds, 3 + s takes the word s slots above.
  localparam logic [2:0] SEL_HOLD = 3'd3;
  localparam logic [2:0] SEL_ROT  = 3'd4;
  localparam logic [2:0] SEL_MAX  = 3'd6;
  localparam int         NBR_CNT  = 7;

  typedef logic [WORD_W-1:0] rsc_word_t;

  typedef enum logic [3:0] {
    ACT_PUSH     = 4'd0,
    ACT_PUSH_RGB = 4'd1,
    ACT_ADD      = 4'd2,
    ACT_SUB      = 4'd3,
    ACT_MUL      = 4'd4,
    ACT_DIV      = 4'd5,
    ACT_DUP      = 4'd6,
    ACT_DROP     = 4'd7,
    ACT_SWAP     = 4'd8,
    ACT_ROT      = 4'd9,
    ACT_CLEAR    = 4'd10,
    ACT_DUMP     = 4'd11,
    ACT_RGB      = 4'd12,
    ACT_HEX      = 4'd13
  } rsc_action_e;

  typedef enum logic [1:0] {
    KIND_ACK    = 2'd0,
    KIND_COLOR  = 2'd1,
    KIND_HEADER = 2'd2,
    KIND_ELEM   = 2'd3
  } rsc_kind_e;

  typedef struct packed {
    rsc_action_e        action;
    logic signed [31:0] operand;
  } rsc_in_t;

  typedef struct packed {
    rsc_kind_e          kind;
    logic signed [31:0] result_value;
    logic [5:0]         stack_depth;
    logic               last;
  } rsc_out_t;

  typedef struct packed {
    logic       en;
    logic [2:0] sel;
  } rsc_shift_t;

endpackage

// File: hw/rtl/rsc_cell.sv
// One stack slot: holds a word and takes it from a neighbor or a load value.
module rsc_cell (
  input  logic                            clk_i,
  input  rsc_pkg::rsc_shift_t             shift_i,
  input  logic                            load_i,
  input  rsc_pkg::rsc_word_t              load_val_i,
  input  logic [rsc_pkg::NBR_CNT-1:0][31:0] nbr_i,
  output rsc_pkg::rsc_word_t              word_o
);
  import rsc_pkg::*;

  rsc_word_t word_q, word_d;

  always_comb begin
    word_d = word_q;
    if (load_i) begin
      word_d = load_val_i;
    end else if (shift_i.sel <= SEL_MAX) begin
      word_d = nbr_i[shift_i.sel];
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i.en) begin
      word_q <= word_d;
    end
  end

  assign word_o = word_q;

endmodule

// File: hw/rtl/rsc_div.sv
// Iterative signed divider, one quotient bit per cycle, zero on a zero divisor.
module rsc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  rsc_pkg::rsc_word_t dividend_i,
  input  rsc_pkg::rsc_word_t divisor_i,
  output logic               done_o,
  output rsc_pkg::rsc_word_t quotient_o
);
  import rsc_pkg::*;

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  rsc_word_t   rem_q, quo_q, den_q;
  logic        neg_q, zero_q;
  logic [32:0] rem_sh, diff;

  assign rem_sh = {rem_q, quo_q[31]};
  assign diff   = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q  <= dividend_i[31] ? (32'd0 - dividend_i) : dividend_i;
      den_q  <= divisor_i[31] ? (32'd0 - divisor_i) : divisor_i;
      rem_q  <= '0;
      neg_q  <= dividend_i[31] ^ divisor_i[31];
      zero_q <= (divisor_i == '0);
    end else if (busy_q) begin
      if (!diff[32]) begin
        rem_q <= diff[31:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= rem_sh[31:0];
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = zero_q ? '0 : (neg_q ? (32'd0 - quo_q) : quo_q);

endmodule

// File: hw/rtl/rpn_stack_calculator.sv
// Top level of the RPN stack calculator: stack slot chain, control and result register.
//
// Usage: each input item carries a pre-classified token (action) and an operand.
// An item is taken when in_valid_i and in_ready_o are both high; in_ready_o is
// high whenever no item is in progress, even while a result still sits in the
// output register waiting for out_ready_i. Results leave on the out channel
// under the same valid/ready rule; last marks the final result of an item.
// Steps: the accepted token is registered; add, sub and mul results are then
// registered; the apply step updates the slots and loads the output register.
// Div waits for the iterative divider before the apply step. A dump loads its
// header in the apply step and then rotates the whole slot ring once, emitting
// the elements bottom first as they pass the last slot. The next item can be
// taken in the cycle after the final result is loaded, not before.
// Reset clears the depth count, control state and the output valid; the slot
// words are left as they are. When the receiver stalls, the output register
// holds its item; the next result and any dump rotation step that emits wait.
module rpn_stack_calculator #(
  parameter int STACK_DEPTH = rsc_pkg::STACK_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rsc_pkg::rsc_in_t in_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rsc_pkg::rsc_out_t out_item_o
);
  import rsc_pkg::*;

  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int KW = $clog2(STACK_DEPTH);
  localparam int CW = (DW > 6) ? DW : 6;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_APPLY = 3'd3;
  localparam logic [2:0] S_DUMP  = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [DW-1:0] depth_q, depth_d;
  rsc_action_e act_q;
  rsc_word_t   opnd_q, res_q, res_d;
  logic [KW-1:0] rot_q, rot_d;
  logic [5:0]  emit_q, emit_d, dump_n_q, dump_n_d;
  logic        out_valid_q, out_valid_d;
  rsc_out_t    out_q, out_d;

  rsc_word_t   stk_word [STACK_DEPTH];
  rsc_word_t   x0, x1, x2;
  rsc_word_t   t0, t1, t2, color, ack_val, quotient;
  logic [1:0]  pop1, pop2, pop3, pop, qpush;
  logic        full, clr, is_dump, is_color, div_start, div_done;
  logic [DW:0] depth_sum;
  logic [DW-1:0] depth_new;
  logic [2:0]  sel_apply;
  logic [5:0]  dump_n;
  logic [CW-1:0] depth_ext;
  logic [DW:0] rot_depth;
  logic        dump_emit, dump_adv, out_free;
  rsc_shift_t  shift;
  logic [2:0]  load;

  // Top three words as seen by pops; missing operands read as zero.
  assign x0 = (depth_q > DW'(0)) ? stk_word[0] : '0;
  assign x1 = (depth_q > DW'(1)) ? stk_word[1] : '0;
  assign x2 = (depth_q > DW'(2)) ? stk_word[2] : '0;

  assign pop1 = (depth_q >= DW'(1)) ? 2'd1 : 2'd0;
  assign pop2 = (depth_q >= DW'(2)) ? 2'd2 : pop1;
  assign pop3 = (depth_q >= DW'(3)) ? 2'd3 : pop2;
  assign full = (depth_q == DW'(STACK_DEPTH));

  assign out_free = !out_valid_q || out_ready_i;

  // Token decode: how many words leave, how many new top words enter.
  always_comb begin
    pop      = 2'd0;
    qpush    = 2'd0;
    t0       = x0;
    t1       = x1;
    t2       = x2;
    clr      = 1'b0;
    is_dump  = 1'b0;
    is_color = 1'b0;
    color    = x0;
    case (act_q)
      ACT_PUSH: begin
        if (!full) begin
          qpush = 2'd1;
          t0    = opnd_q;
        end
      end
      ACT_PUSH_RGB: begin
        if (!full) begin
          qpush = 2'd1;
          t0    = {ALPHA_OPAQUE, opnd_q[7:0], opnd_q[15:8], opnd_q[23:16]};
        end
      end
      ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV: begin
        pop   = pop2;
        qpush = 2'd1;
        t0    = res_q;
      end
      ACT_DUP: begin
        if (depth_q != '0 && !full) begin
          pop   = 2'd1;
          qpush = 2'd2;
          t0    = x0;
          t1    = x0;
        end
      end
      ACT_DROP: pop = pop1;
      ACT_SWAP: begin
        pop   = pop2;
        qpush = 2'd2;
        t0    = x1;
        t1    = x0;
      end
      ACT_ROT: begin
        pop   = pop3;
        qpush = 2'd3;
        t0    = x2;
        t1    = x0;
        t2    = x1;
      end
      ACT_CLEAR: clr = 1'b1;
      ACT_DUMP:  is_dump = 1'b1;
      ACT_RGB: begin
        pop      = pop3;
        is_color = 1'b1;
        color    = {ALPHA_OPAQUE, x0[7:0], x1[7:0], x2[7:0]};
      end
      ACT_HEX: begin
        pop      = pop1;
        is_color = 1'b1;
        color    = x0;
      end
      default: ;
    endcase
  end

  assign depth_sum = (DW+1)'(depth_q) - (DW+1)'(pop) + (DW+1)'(qpush);
  assign depth_new = clr ? '0 : depth_sum[DW-1:0];
  assign sel_apply = SEL_HOLD + {1'b0, qpush} - {1'b0, pop};

  always_comb begin
    if (depth_new == '0) begin
      ack_val = '0;
    end else if (qpush != 2'd0) begin
      ack_val = t0;
    end else if (pop == 2'd1) begin
      ack_val = x1;
    end else begin
      ack_val = x0;
    end
  end

  // Dump: count of elements shown, capped at the dump limit.
  assign depth_ext = CW'(depth_q);
  assign dump_n    = (depth_ext > CW'(DUMP_MAX)) ? 6'(DUMP_MAX) : depth_ext[5:0];

  // During the ring rotation the bottom word reaches the last slot after
  // STACK_DEPTH - depth steps; the next ones follow one per step.
  assign rot_depth = (DW+1)'(rot_q) + (DW+1)'(depth_q);
  assign dump_emit = (rot_depth >= (DW+1)'(STACK_DEPTH)) && (emit_q < dump_n_q);
  assign dump_adv  = !dump_emit || out_free;

  always_comb begin
    res_d = res_q;
    case (act_q)
      ACT_ADD: res_d = x1 + x0;
      ACT_SUB: res_d = x1 - x0;
      ACT_MUL: res_d = x1 * x0;
      default: ;
    endcase
  end

  assign div_start = (state_q == S_EXEC) && (act_q == ACT_DIV);

  always_comb begin
    state_d     = state_q;
    depth_d     = depth_q;
    rot_d       = rot_q;
    emit_d      = emit_q;
    dump_n_d    = dump_n_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    shift.en    = 1'b0;
    shift.sel   = SEL_HOLD;
    load        = 3'b000;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = (act_q == ACT_DIV) ? S_DIV : S_APPLY;
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (is_dump) begin
            out_d.kind         = KIND_HEADER;
            out_d.result_value = 32'(depth_q);
            out_d.stack_depth  = 6'(depth_q);
            out_d.last         = (dump_n == '0);
            dump_n_d = dump_n;
            rot_d    = '0;
            emit_d   = '0;
            state_d  = (dump_n == '0) ? S_IDLE : S_DUMP;
          end else begin
            shift.en  = 1'b1;
            shift.sel = sel_apply;
            load[0]   = (qpush >= 2'd1);
            load[1]   = (qpush >= 2'd2);
            load[2]   = (qpush >= 2'd3);
            depth_d   = depth_new;
            out_d.kind         = is_color ? KIND_COLOR : KIND_ACK;
            out_d.result_value = is_color ? color : ack_val;
            out_d.stack_depth  = 6'(depth_new);
            out_d.last         = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      S_DUMP: begin
        if (dump_adv) begin
          shift.en  = 1'b1;
          shift.sel = SEL_ROT;
          rot_d     = rot_q + KW'(1);
          if (dump_emit) begin
            out_valid_d        = 1'b1;
            out_d.kind         = KIND_ELEM;
            out_d.result_value = stk_word[STACK_DEPTH-1];
            out_d.stack_depth  = 6'(depth_q);
            out_d.last         = (emit_q == dump_n_q - 6'd1);
            emit_d = emit_q + 6'd1;
          end
          if (rot_q == KW'(STACK_DEPTH - 1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      depth_q     <= '0;
      out_valid_q <= 1'b0;
      rot_q       <= '0;
      emit_q      <= '0;
      dump_n_q    <= '0;
    end else begin
      state_q     <= state_d;
      depth_q     <= depth_d;
      out_valid_q <= out_valid_d;
      rot_q       <= rot_d;
      emit_q      <= emit_d;
      dump_n_q    <= dump_n_d;
    end
  end

  // Payload registers: token, arithmetic result, output item.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      act_q  <= in_item_i.action;
      opnd_q <= in_item_i.operand;
    end
    if (state_q == S_EXEC) begin
      res_q <= res_d;
    end else if (state_q == S_DIV && div_done) begin
      res_q <= quotient;
    end
    out_q <= out_d;
  end

  rsc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (x1),
    .divisor_i  (x0),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Slot chain: slot 0 is the top; each slot reaches three neighbors either way,
  // and the ring wraps so that the dump can rotate it.
  for (genvar j = 0; j < STACK_DEPTH; j++) begin : g_slot
    logic [NBR_CNT-1:0][31:0] nbr;
    logic      ld;
    rsc_word_t ld_val;
    for (genvar m = 0; m < NBR_CNT; m++) begin : g_nbr
      assign nbr[m] = stk_word[(j + 3 - m + STACK_DEPTH) % STACK_DEPTH];
    end
    if (j == 0) begin : g_l0
      assign ld     = load[0];
      assign ld_val = t0;
    end else if (j == 1) begin : g_l1
      assign ld     = load[1];
      assign ld_val = t1;
    end else if (j == 2) begin : g_l2
      assign ld     = load[2];
      assign ld_val = t2;
    end else begin : g_lx
      assign ld     = 1'b0;
      assign ld_val = '0;
    end
    rsc_cell u_slot (
      .clk_i      (clk_i),
      .shift_i    (shift),
      .load_i     (ld),
      .load_val_i (ld_val),
      .nbr_i      (nbr),
      .word_o     (stk_word[j])
    );
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: hw/rtl/rsc_checker.sv
// Port-level checks of the RPN stack calculator, bound to the top level.
module rsc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input rsc_pkg::rsc_in_t  in_item_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input rsc_pkg::rsc_out_t out_item_o
);
  import rsc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_item_o))
    else $error("output item changed while stalled");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.kind == KIND_ACK || out_item_o.kind == KIND_COLOR)
    |-> out_item_o.last)
    else $error("single-result item without last");

  a_empty_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.kind == KIND_HEADER && out_item_o.result_value == 0
    |-> out_item_o.last)
    else $error("empty dump header without last");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken while one is in progress");

endmodule

bind rpn_stack_calculator rsc_checker u_rsc_checker (.*);

// File: dv/tb.sv
// Self-checking testbench of the RPN stack calculator: token stimulus, stack predictor, checks.
`timescale 1ns / 100ps

module tb;
  import rsc_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES   = STACK_DEPTH_DEF + 8;
  // Action codes with no operation behind them; the block only acknowledges them.
  localparam logic [3:0]  ACT_SPARE_A    = 4'd14;
  localparam logic [3:0]  ACT_SPARE_B    = 4'd15;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  rsc_in_t  in_item_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  rsc_out_t out_item_o;

  // Percent of cycles in which the token source holds off and the sink stalls.
  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned err_count      = 0;
  int unsigned idle_cycles    = 0;

  // Predicted stack contents and the results still owed by the block.
  logic [31:0] calc_stack [STACK_DEPTH_DEF];
  int unsigned calc_depth = 0;
  rsc_out_t    owed_results[$];

  rpn_stack_calculator #(
    .STACK_DEPTH(STACK_DEPTH_DEF)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Stack predictor
  // ---------------------------------------------------------------------------

  // Pop one word; an empty stack reads as zero.
  function automatic logic [31:0] calc_pop();
    if (calc_depth > 0) begin
      calc_depth--;
      return calc_stack[calc_depth];
    end
    return '0;
  endfunction

  // Push one word; drop it when the stack is full.
  function automatic void calc_push(input logic [31:0] word);
    if (calc_depth < STACK_DEPTH_DEF) begin
      calc_stack[calc_depth] = word;
      calc_depth++;
    end
  endfunction

  function automatic logic [31:0] calc_top();
    return (calc_depth > 0) ? calc_stack[calc_depth-1] : '0;
  endfunction

  // Signed division truncating toward zero; divide by zero gives zero and the
  // most negative word over minus one wraps back to itself.
  function automatic logic [31:0] calc_quotient(input logic [31:0] num, input logic [31:0] den);
    logic [31:0] mag_n, mag_d, quo;
    if (den == '0) return '0;
    mag_n = num[31] ? -num : num;
    mag_d = den[31] ? -den : den;
    quo   = mag_n / mag_d;
    return (num[31] ^ den[31]) ? -quo : quo;
  endfunction

  function automatic void owe_result(input rsc_kind_e kind, input logic [31:0] value,
                                     input logic last);
    rsc_out_t res;
    res.kind         = kind;
    res.result_value = value;
    res.stack_depth  = calc_depth[5:0];
    res.last         = last;
    owed_results.push_back(res);
  endfunction

  // Advance the predicted stack by one token and queue the results it causes.
  function automatic void calc_token(input logic [3:0] act, input logic [31:0] opnd);
    logic [31:0] x, y, z;
    int unsigned n;
    case (act)
      ACT_PUSH:     calc_push(opnd);
      ACT_PUSH_RGB: calc_push({ALPHA_OPAQUE, opnd[7:0], opnd[15:8], opnd[23:16]});
      ACT_ADD: begin
        y = calc_pop(); x = calc_pop(); calc_push(x + y);
      end
      ACT_SUB: begin
        y = calc_pop(); x = calc_pop(); calc_push(x - y);
      end
      ACT_MUL: begin
        y = calc_pop(); x = calc_pop(); calc_push(x * y);
      end
      ACT_DIV: begin
        y = calc_pop(); x = calc_pop(); calc_push(calc_quotient(x, y));
      end
      ACT_DUP: begin
        if (calc_depth > 0) calc_push(calc_top());
      end
      ACT_DROP:     x = calc_pop();
      ACT_SWAP: begin
        y = calc_pop(); x = calc_pop(); calc_push(y); calc_push(x);
      end
      ACT_ROT: begin
        z = calc_pop(); y = calc_pop(); x = calc_pop();
        calc_push(y); calc_push(z); calc_push(x);
      end
      ACT_CLEAR:    calc_depth = 0;
      ACT_DUMP: begin
        n = (calc_depth > DUMP_MAX) ? DUMP_MAX : calc_depth;
        owe_result(KIND_HEADER, calc_depth, n == 0);
        for (int unsigned i = 0; i < n; i++) begin
          owe_result(KIND_ELEM, calc_stack[i], i + 1 == n);
        end
        return;
      end
      ACT_RGB: begin
        z = calc_pop(); y = calc_pop(); x = calc_pop();
        owe_result(KIND_COLOR, {ALPHA_OPAQUE, z[7:0], y[7:0], x[7:0]}, 1'b1);
        return;
      end
      ACT_HEX: begin
        x = calc_pop();
        owe_result(KIND_COLOR, x, 1'b1);
        return;
      end
      default: ;
    endcase
    owe_result(KIND_ACK, calc_top(), 1'b1);
  endfunction

  // ---------------------------------------------------------------------------
  // Token source, result sink, checks and watchdog
  // ---------------------------------------------------------------------------

  // Drive one token, hold it until the block takes it, then predict its results.
  task automatic send_token(input logic [3:0] act, input logic [31:0] opnd);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= '{action: rsc_action_e'(act), operand: opnd};
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    calc_token(act, opnd);
  endtask

  // Hold off the source until every owed result has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (owed_results.size() != 0);
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Sample at the falling edge: what is seen here is what the next rising
  // edge takes, so no check depends on event order within a time step.
  always @(negedge clk_i) begin
    rsc_out_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = out_item_o;
      if (owed_results.size() == 0) begin
        $error("result with none owed: kind %0d value %h depth %0d last %0b",
               got.kind, got.result_value, got.stack_depth, got.last);
        err_count++;
      end else begin
        want = owed_results.pop_front();
        if (got.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, got.kind);
          err_count++;
        end
        if (got.result_value !== want.result_value) begin
          $error("result_value: expected %h, got %h", want.result_value, got.result_value);
          err_count++;
        end
        if (got.stack_depth !== want.stack_depth) begin
          $error("stack_depth: expected %0d, got %0d", want.stack_depth, got.stack_depth);
          err_count++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, got.last);
          err_count++;
        end
      end
    end
  end

  // Count cycles in which neither channel moves an item; stop on a hang.
  always @(negedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved in %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Mix small values, extremes and raw random words.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(5))
      0: return $urandom_range(9, 0);
      1: return -$urandom_range(9, 1);
      2: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Empty-stack corner cases, wrapping arithmetic, division corners and every action at least once.
  task automatic test_directed();
    send_gap_pct   = 16;
    recv_stall_pct = 16;
    send_token(ACT_DUP,      $urandom);      // dup on empty: no change
    send_token(ACT_DROP,     $urandom);      // pop of empty reads zero
    send_token(ACT_ADD,      $urandom);      // short stack still pushes a zero
    send_token(ACT_CLEAR,    $urandom);
    send_token(ACT_DUMP,     $urandom);      // header alone carries last
    send_token(ACT_PUSH,     32'h7FFF_FFFF);
    send_token(ACT_PUSH,     32'h0000_0001);
    send_token(ACT_ADD,      $urandom);      // wraps to most negative
    send_token(ACT_PUSH,     32'hFFFF_FFFF);
    send_token(ACT_DIV,      $urandom);      // most negative over minus one
    send_token(ACT_PUSH,     32'h0);
    send_token(ACT_DIV,      $urandom);      // divide by zero
    send_token(ACT_PUSH,     32'h1234_5679);
    send_token(ACT_PUSH,     32'h7FFF_FFFF);
    send_token(ACT_MUL,      $urandom);
    send_token(ACT_PUSH_RGB, 32'hA5FF_00C3); // top byte ignored
    send_token(ACT_PUSH_RGB, 32'h0000_0000);
    send_token(ACT_SWAP,     $urandom);
    send_token(ACT_ROT,      $urandom);
    send_token(ACT_DUP,      $urandom);
    send_token(ACT_SUB,      $urandom);
    send_token(ACT_DUMP,     $urandom);
    send_token(ACT_HEX,      $urandom);
    send_token(ACT_RGB,      $urandom);      // pops the last three words
    send_token(ACT_SPARE_A,  $urandom);
    send_token(ACT_SPARE_B,  $urandom);
    wait_drained();
  endtask

  // Fill the stack, push past the top, and dump the full stack.
  task automatic test_full_stack();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    send_token(ACT_CLEAR, $urandom);
    for (int i = 0; i < STACK_DEPTH_DEF; i++) begin
      send_token(ACT_PUSH, $urandom);
    end
    send_token(ACT_PUSH,     $urandom);      // full: ignored but acknowledged
    send_token(ACT_PUSH_RGB, $urandom);
    send_token(ACT_DUP,      $urandom);
    send_token(ACT_DUMP,     $urandom);      // largest burst of results
    send_token(ACT_ROT,      $urandom);
    send_token(ACT_SWAP,     $urandom);
    wait_drained();
  endtask

  // Random tokens weighted toward pushes so the stack moves over its whole range;
  // push bursts now and then fill it up. If the count sent hits exactly half, drain all there.
  task automatic test_random(input int unsigned count, input int unsigned gap_pct,
                             input int unsigned stall_pct);
    int unsigned sent;
    int unsigned roll;
    int unsigned burst;
    sent           = 0;
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    while (sent < count) begin
      roll = $urandom_range(99);
      if (roll < 4) begin
        burst = $urandom_range(12, 4);
        for (int unsigned i = 0; i < burst; i++) begin
          send_token(ACT_PUSH, pick_operand());
        end
        sent += burst;
      end else begin
        if (roll < 34)      send_token(ACT_PUSH, pick_operand());
        else if (roll < 42) send_token(ACT_PUSH_RGB, $urandom);
        else if (roll < 46) send_token(ACT_DUMP, $urandom);
        else                send_token(4'($urandom_range(15, 2)), $urandom);
        sent++;
      end
      if (sent == count / 2) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_full_stack();
    test_random(95, 0, 0);
    test_random(95, 79, 0);
    test_random(95, 0, 79);
    test_random(95, 16, 16);

    // Let any stray result show up before the verdict.
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (owed_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/rsc_pkg.sv
hw/rtl/rsc_cell.sv
hw/rtl/rsc_div.sv
hw/rtl/rpn_stack_calculator.sv
hw/rtl/rsc_checker.sv
dv/tb.sv
